@@ rtl/utf8sd_pkg.sv @@
// Package for the UTF-8 sanitising decoder: result types, constants and helpers.
`timescale 1ns / 1ps

package utf8sd_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned UsedW   = 3;
  localparam int unsigned MaxRes  = 4;
  localparam int unsigned CntW    = 3;

  localparam logic [CpW-1:0] EscBase  = 21'h00DC00;
  localparam logic [CpW-1:0] CpMax    = 21'h10FFFF;
  localparam logic [CpW-1:0] SurLo    = 21'h00D800;
  localparam logic [CpW-1:0] SurHi    = 21'h00DFFF;
  localparam logic [CpW-1:0] Min2     = 21'h000080;
  localparam logic [CpW-1:0] Min3     = 21'h000800;
  localparam logic [CpW-1:0] Min4     = 21'h010000;

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] Len2    = 3'd2;
  localparam logic [2:0] Len3    = 3'd3;
  localparam logic [2:0] Len4    = 3'd4;

  // One result word
  typedef struct packed {
    logic [CpW-1:0]   code_point;
    logic             escaped;
    logic [UsedW-1:0] bytes_used;
    logic             last_of_run;
  } res_t;

  // All results caused by one input byte
  typedef struct packed {
    res_t [MaxRes-1:0] item;
    logic [CntW-1:0]   count;
  } burst_t;

  // Escape one raw byte to 0xDC00 plus the byte
  function automatic res_t esc_item(input logic [7:0] b);
    res_t r;
    r.code_point  = EscBase | {13'd0, b};
    r.escaped     = 1'b1;
    r.bytes_used  = 3'd1;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Plain decoded code point
  function automatic res_t cp_item(input logic [CpW-1:0] cp, input logic [UsedW-1:0] used);
    res_t r;
    r.code_point  = cp;
    r.escaped     = 1'b0;
    r.bytes_used  = used;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/utf8_sanitizing_decoder.sv @@
// Top level of the UTF-8 sanitising decoder.
`timescale 1ns / 1ps

// Takes one UTF-8 byte per cycle unless stalled and returns code points;
// every byte that cannot form a valid shortest-form scalar value comes out
// as 0xDC00 plus the byte, with escaped set. A byte is decoded in the cycle
// it is taken and its results (zero to four words) sit in a result register
// from the next cycle on, one word per cycle unless out_stall is high.
// A byte that gives at most one word keeps a rate of one byte per clock
// without output stall; more words hold off the next byte while they drain.
// Output stall stalls the input only once the last pending word is blocked.

module utf8_sanitizing_decoder
  import utf8sd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_end_of_input,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CpW-1:0]       out_code_point,
  output logic                 out_escaped,
  output logic [UsedW-1:0]     out_bytes_used,
  output logic                 out_last_of_run
);

  burst_t burst;
  res_t   head;
  logic   room;
  logic   accept;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  utf8sd_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_data_byte),
    .end_of_input (in_end_of_input),
    .burst        (burst)
  );

  utf8sd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .burst     (burst),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (head),
    .room      (room)
  );

  assign out_code_point  = head.code_point;
  assign out_escaped     = head.escaped;
  assign out_bytes_used  = head.bytes_used;
  assign out_last_of_run = head.last_of_run;

endmodule

@@ rtl/utf8sd_decode.sv @@
// Sequence state and single-pass decode of one byte into its burst of results.
`timescale 1ns / 1ps

module utf8sd_decode
  import utf8sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_input,
  output burst_t     burst
);

  logic [7:0]     lead_r, lead_nxt;
  logic [2:0]     exp_r, exp_nxt;
  logic [1:0]     held_r, held_nxt;
  logic [5:0]     tail0_r, tail0_nxt;
  logic [5:0]     tail1_r, tail1_nxt;
  logic [CntW-1:0] cnt;
  logic           is_cont;
  logic           completes;
  logic [CpW-1:0] value;
  logic [CpW-1:0] lo_bound;
  logic           value_ok;
  burst_t         burst_nxt;

  assign is_cont   = (data_byte[7:6] == 2'b10);
  assign completes = (({1'b0, held_r} + 3'd2) >= exp_r) || (held_r >= 2'd2);

  // Assemble the candidate code point from lead, held tails and this byte
  always_comb begin
    case (exp_r)
      Len2: begin
        value    = {10'd0, lead_r[4:0], data_byte[5:0]};
        lo_bound = Min2;
      end
      Len3: begin
        value    = {5'd0, lead_r[3:0], tail0_r, data_byte[5:0]};
        lo_bound = Min3;
      end
      default: begin
        value    = {lead_r[2:0], tail0_r, tail1_r, data_byte[5:0]};
        lo_bound = Min4;
      end
    endcase
  end

  assign value_ok = (value >= lo_bound) && (value <= CpMax) &&
                    !((value >= SurLo) && (value <= SurHi));

  // Work out next state and the ordered list of results
  always_comb begin
    burst_nxt = '0;
    cnt       = '0;
    lead_nxt  = lead_r;
    exp_nxt   = exp_r;
    held_nxt  = held_r;
    tail0_nxt = tail0_r;
    tail1_nxt = tail1_r;

    if ((exp_r != LenNone) && is_cont) begin
      if (completes) begin
        if (value_ok) begin
          burst_nxt.item[cnt[1:0]] = cp_item(value, exp_r);
          cnt = cnt + 3'd1;
        end else begin
          // reject: escape lead, held tails, then this byte
          burst_nxt.item[cnt[1:0]] = esc_item(lead_r);
          cnt = cnt + 3'd1;
          if (held_r >= 2'd1) begin
            burst_nxt.item[cnt[1:0]] = esc_item({2'b10, tail0_r});
            cnt = cnt + 3'd1;
          end
          if (held_r >= 2'd2) begin
            burst_nxt.item[cnt[1:0]] = esc_item({2'b10, tail1_r});
            cnt = cnt + 3'd1;
          end
          burst_nxt.item[cnt[1:0]] = esc_item(data_byte);
          cnt = cnt + 3'd1;
        end
        exp_nxt  = LenNone;
        held_nxt = 2'd0;
      end else begin
        // hold another continuation byte
        if (held_r[0]) begin
          tail1_nxt = data_byte[5:0];
        end else begin
          tail0_nxt = data_byte[5:0];
        end
        held_nxt = held_r + 2'd1;
      end
    end else begin
      // broken sequence: drop it as escapes
      if (exp_r != LenNone) begin
        burst_nxt.item[cnt[1:0]] = esc_item(lead_r);
        cnt = cnt + 3'd1;
        if (held_r >= 2'd1) begin
          burst_nxt.item[cnt[1:0]] = esc_item({2'b10, tail0_r});
          cnt = cnt + 3'd1;
        end
        if (held_r >= 2'd2) begin
          burst_nxt.item[cnt[1:0]] = esc_item({2'b10, tail1_r});
          cnt = cnt + 3'd1;
        end
        exp_nxt  = LenNone;
        held_nxt = 2'd0;
      end
      // handle this byte as a lead
      if (!data_byte[7]) begin
        if (data_byte == 8'd0) begin
          burst_nxt.item[cnt[1:0]] = esc_item(data_byte);
        end else begin
          burst_nxt.item[cnt[1:0]] = cp_item({13'd0, data_byte}, 3'd1);
        end
        cnt = cnt + 3'd1;
      end else if (data_byte[7:5] == 3'b110) begin
        lead_nxt = data_byte;
        exp_nxt  = Len2;
        held_nxt = 2'd0;
      end else if (data_byte[7:4] == 4'b1110) begin
        lead_nxt = data_byte;
        exp_nxt  = Len3;
        held_nxt = 2'd0;
      end else if (data_byte[7:3] == 5'b11110) begin
        lead_nxt = data_byte;
        exp_nxt  = Len4;
        held_nxt = 2'd0;
      end else begin
        burst_nxt.item[cnt[1:0]] = esc_item(data_byte);
        cnt = cnt + 3'd1;
      end
    end

    // end of input: flush whatever is still pending
    if (end_of_input && (exp_nxt != LenNone)) begin
      burst_nxt.item[cnt[1:0]] = esc_item(lead_nxt);
      cnt = cnt + 3'd1;
      if (held_nxt >= 2'd1) begin
        burst_nxt.item[cnt[1:0]] = esc_item({2'b10, tail0_nxt});
        cnt = cnt + 3'd1;
      end
      if (held_nxt >= 2'd2) begin
        burst_nxt.item[cnt[1:0]] = esc_item({2'b10, tail1_nxt});
        cnt = cnt + 3'd1;
      end
      exp_nxt  = LenNone;
      held_nxt = 2'd0;
    end

    // mark the final word of the run
    if (cnt != '0) begin
      burst_nxt.item[cnt[1:0] - 2'd1].last_of_run = 1'b1;
    end
    burst_nxt.count = cnt;
  end

  assign burst = burst_nxt;

  // Advance sequence state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= 8'd0;
      exp_r  <= LenNone;
      held_r <= 2'd0;
    end else if (accept) begin
      lead_r <= lead_nxt;
      exp_r  <= exp_nxt;
      held_r <= held_nxt;
    end
  end

  // Tail bytes carry no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      tail0_r <= tail0_nxt;
      tail1_r <= tail1_nxt;
    end
  end

endmodule

@@ rtl/utf8sd_outbuf.sv @@
// Result register: holds one byte's burst and hands it out a word at a time.
`timescale 1ns / 1ps

module utf8sd_outbuf
  import utf8sd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   load,
  input  burst_t burst,
  input  logic   out_stall,
  output logic   out_valid,
  output res_t   head,
  output logic   room
);

  res_t [MaxRes-1:0] item_r, item_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              take;

  assign out_valid = (cnt_r != '0);
  assign take      = out_valid && !out_stall;
  assign head      = item_r[0];
  // Take a new burst when empty or once the last word held leaves this cycle
  assign room      = (cnt_r == '0) || ((cnt_r == 3'd1) && !out_stall);

  // Load a fresh burst or shift the next word to the head
  always_comb begin
    item_nxt = item_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      item_nxt = burst.item;
      cnt_nxt  = burst.count;
    end else if (take) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        item_nxt[i] = item_r[i+1];
      end
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

@@ rtl/utf8sd_checker.sv @@
// Port-level checks for the UTF-8 sanitising decoder, bound to the top level.
`timescale 1ns / 1ps

module utf8sd_checker
  import utf8sd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [7:0]       in_data_byte,
  input logic             in_end_of_input,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CpW-1:0]   out_code_point,
  input logic             out_escaped,
  input logic [UsedW-1:0] out_bytes_used,
  input logic             out_last_of_run
);

  // A stalled input word stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data_byte) && $stable(in_end_of_input))
    else $error("input word changed while stalled");

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_code_point) && $stable(out_escaped) &&
      $stable(out_bytes_used) && $stable(out_last_of_run))
    else $error("stalled result word changed");

  // An escape wraps exactly one byte in the 0xDC00 block
  a_escape_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_escaped |->
      (out_bytes_used == 3'd1) && (out_code_point[CpW-1:8] == EscBase[CpW-1:8]))
    else $error("malformed escape word");

  // A decoded word is a nonzero scalar value from one to four bytes
  a_decoded_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_escaped |->
      (out_code_point != '0) && (out_code_point <= CpMax) &&
      !((out_code_point >= SurLo) && (out_code_point <= SurHi)) &&
      (out_bytes_used != 3'd0) && (out_bytes_used <= 3'd4))
    else $error("decoded word out of range");

endmodule

bind utf8_sanitizing_decoder utf8sd_checker u_utf8sd_checker (.*);
